// ===== design/byte_escape_codec_macros.svh =====
// ----------------------------------------------------------------------------
// Byte escape codec assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_ESCAPE_CODEC_MACROS_SVH
`define BYTE_ESCAPE_CODEC_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define BEC_ASSERT_NOW(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define BEC_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ===== design/bec_pkg.sv =====
// ----------------------------------------------------------------------------
// Byte escape codec package
// Payload, command and configuration types shared by the codec modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bec_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE        = 3'd0,
    CFG_FLAG_BYTE   = 3'd1,
    CFG_ESCAPE_BYTE = 3'd2,
    CFG_FLAG_CODE   = 3'd3,
    CFG_ESCAPE_CODE = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  localparam logic [BYTE_W-1:0] FLAG_BYTE_RST   = 8'd126;
  localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RST = 8'd125;
  localparam logic [BYTE_W-1:0] FLAG_CODE_RST   = 8'd2;
  localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd1;

  typedef struct packed {
    logic [BYTE_W-1:0] data_in;
    logic              last_in;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_out;
    logic              last_out;
  } out_item_t;

  // One classified input byte: one or two output bytes.
  typedef struct packed {
    out_item_t first;
    out_item_t second;
    logic      two;
  } cmd_t;

endpackage

`default_nettype wire

// ===== design/byte_escape_codec.sv =====
// ----------------------------------------------------------------------------
// Byte escape codec
// Byte-stuffing encoder and decoder for framed byte streams.
// ----------------------------------------------------------------------------
// Input bytes are written with in_push while in_full is low; results are read
// from out_item while out_empty is low and taken with out_pop. Registers are
// written through cfg_we, cfg_idx and cfg_data; the user must write them only
// while the codec is idle, which the codec itself does not enforce. A write to
// the mode register also drops a held escape. The front end classifies one
// byte per cycle while the queue has room into a command of zero, one or two
// output bytes and pushes each non-empty command into a short queue. The back
// end issues one output byte per cycle into the output register while the
// reader keeps up. Throughput is set by that single output port, which carries
// every result byte; a decoder escape that is held yields none. When the
// reader stalls, the output register holds its byte, the queue fills and
// in_full rises. Reset empties the queue and the output register, clears the
// held escape and restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_escape_codec #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [bec_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [bec_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            in_push,
  input  wire bec_pkg::in_item_t               in_item,
  output logic                                 in_full,
  input  wire logic                            out_pop,
  output logic                                 out_empty,
  output bec_pkg::out_item_t                   out_item
);

  logic           q_push;
  logic           q_pop;
  logic           q_empty;
  bec_pkg::cmd_t  q_cmd;
  bec_pkg::cmd_t  head_cmd;

  bec_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_push  (in_push),
    .in_item  (in_item),
    .q_full   (in_full),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  bec_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (in_full),
    .empty    (q_empty)
  );

  bec_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_cmd  (head_cmd),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== design/bec_front.sv =====
// ----------------------------------------------------------------------------
// Byte escape codec front end
// Holds the configuration, classifies each input byte into a command of zero,
// one or two output bytes and tracks the decoder's pending escape.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_escape_codec_macros.svh"

module bec_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [bec_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [bec_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_push,
  input  wire bec_pkg::in_item_t                 in_item,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output bec_pkg::cmd_t                          q_cmd
);

  bec_pkg::mode_t              mode_r;
  logic [bec_pkg::BYTE_W-1:0]  flag_byte_r;
  logic [bec_pkg::BYTE_W-1:0]  escape_byte_r;
  logic [bec_pkg::BYTE_W-1:0]  flag_code_r;
  logic [bec_pkg::BYTE_W-1:0]  escape_code_r;
  logic                        pend_r;
  logic                        pend_nxt;
  logic                        accept;

  assign accept = in_push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= bec_pkg::MODE_ENCODE;
      flag_byte_r   <= bec_pkg::FLAG_BYTE_RST;
      escape_byte_r <= bec_pkg::ESCAPE_BYTE_RST;
      flag_code_r   <= bec_pkg::FLAG_CODE_RST;
      escape_code_r <= bec_pkg::ESCAPE_CODE_RST;
      pend_r        <= 1'b0;
    end else begin
      if (cfg_we && (bec_pkg::cfg_idx_t'(cfg_idx) == bec_pkg::CFG_MODE)) begin
        pend_r <= 1'b0;
      end else if (accept) begin
        pend_r <= pend_nxt;
      end
      if (cfg_we) begin
        unique case (bec_pkg::cfg_idx_t'(cfg_idx))
          bec_pkg::CFG_MODE:        mode_r        <= bec_pkg::mode_t'(cfg_data[0]);
          bec_pkg::CFG_FLAG_BYTE:   flag_byte_r   <= cfg_data;
          bec_pkg::CFG_ESCAPE_BYTE: escape_byte_r <= cfg_data;
          bec_pkg::CFG_FLAG_CODE:   flag_code_r   <= cfg_data;
          bec_pkg::CFG_ESCAPE_CODE: escape_code_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    logic [bec_pkg::BYTE_W-1:0] b;
    logic                       last;
    logic                       emit;
    b          = in_item.data_in;
    last       = in_item.last_in;
    emit       = 1'b1;
    pend_nxt   = 1'b0;
    q_cmd      = '0;
    if (mode_r == bec_pkg::MODE_ENCODE) begin
      if (b == flag_byte_r) begin
        q_cmd.first  = '{data_out: escape_byte_r, last_out: 1'b0};
        q_cmd.second = '{data_out: flag_code_r, last_out: last};
        q_cmd.two    = 1'b1;
      end else if (b == escape_byte_r) begin
        q_cmd.first  = '{data_out: escape_byte_r, last_out: 1'b0};
        q_cmd.second = '{data_out: escape_code_r, last_out: last};
        q_cmd.two    = 1'b1;
      end else begin
        q_cmd.first = '{data_out: b, last_out: last};
      end
    end else if (pend_r && b == flag_code_r) begin
      q_cmd.first = '{data_out: flag_byte_r, last_out: last};
    end else if (pend_r && b == escape_code_r) begin
      q_cmd.first = '{data_out: escape_byte_r, last_out: last};
    end else if (pend_r) begin
      q_cmd.first = '{data_out: escape_byte_r, last_out: 1'b0};
      if (b == escape_byte_r && !last) begin
        pend_nxt = 1'b1;
      end else begin
        q_cmd.second = '{data_out: b, last_out: last};
        q_cmd.two    = 1'b1;
      end
    end else if (b == escape_byte_r && !last) begin
      pend_nxt = 1'b1;
      emit     = 1'b0;
    end else begin
      q_cmd.first = '{data_out: b, last_out: last};
    end
    q_push = accept && emit;
  end

  `BEC_ASSERT_NOW(a_enc_no_pend, mode_r == bec_pkg::MODE_ENCODE, !pend_r, "Escape held in encoder")
  `BEC_ASSERT_NOW(a_push_room, q_push, !q_full, "Command written into a full queue")

endmodule

`default_nettype wire

// ===== design/bec_queue.sv =====
// ----------------------------------------------------------------------------
// Byte escape codec command queue
// Short first-in first-out queue of commands between front end and back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_escape_codec_macros.svh"

module bec_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire bec_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output bec_pkg::cmd_t       head_cmd,
  output logic                full,
  output logic                empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  bec_pkg::cmd_t     slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == CNT_FULL);
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `BEC_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_FULL, "Queue count beyond depth")
  `BEC_ASSERT_NEXT(a_push_fill, do_push && !do_pop, !empty, "Queue empty after a write")

endmodule

`default_nettype wire

// ===== design/bec_back.sv =====
// ----------------------------------------------------------------------------
// Byte escape codec back end
// Expands queued commands into output bytes, one per cycle while the output
// register, which the result channel reads, is empty or being read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "byte_escape_codec_macros.svh"

module bec_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bec_pkg::cmd_t  head_cmd,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire logic           out_pop,
  output logic                out_empty,
  output bec_pkg::out_item_t  out_item
);

  bec_pkg::out_item_t  out_item_r;
  bec_pkg::out_item_t  out_item_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                phase_r;
  logic                phase_nxt;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  always_comb begin
    logic load;
    load          = !out_valid_r || out_pop;
    out_item_nxt  = out_item_r;
    out_valid_nxt = out_valid_r;
    phase_nxt     = phase_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = !q_empty;
      if (!q_empty) begin
        out_item_nxt = phase_r ? head_cmd.second : head_cmd.first;
        if (phase_r || !head_cmd.two) begin
          q_pop     = 1'b1;
          phase_nxt = 1'b0;
        end else begin
          phase_nxt = 1'b1;
        end
      end
    end
  end

  `BEC_ASSERT_NOW(a_phase_has_cmd, phase_r, !q_empty, "Second byte pending with no command")
  `BEC_ASSERT_NOW(a_pop_has_cmd, q_pop, !q_empty, "Command taken from an empty queue")

endmodule

`default_nettype wire
